// File: rtl/curve_number_runoff_unit_assert.svh
// ---------------------------------------------------------------------------
// curve_number_runoff_unit assertion macros
// Concurrent assertion wrappers; empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef CURVE_NUMBER_RUNOFF_UNIT_ASSERT_SVH
`define CURVE_NUMBER_RUNOFF_UNIT_ASSERT_SVH
`ifndef SYNTH
// checked only out of reset
`define CNR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked on every edge
`define CNR_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CNR_ASSERT(lbl, prop, msg)
`define CNR_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: rtl/cnr_pkg.sv
// ---------------------------------------------------------------------------
// cnr_pkg
// Types and constants of the curve number runoff unit.
// ---------------------------------------------------------------------------
package cnr_pkg;

	typedef struct packed {
		logic [15:0] moisture_a;
		logic [15:0] moisture_b;
		logic [23:0] rainfall;
	} item_t;

	typedef struct packed {
		logic [16:0] moisture_excess;
		logic [23:0] retention;
		logic [23:0] initial_abstraction;
		logic [14:0] curve_number;
		logic [23:0] runoff;
	} result_t;

	typedef enum logic [1:0] {
		CFG_WILTING_SUM   = 2'd0,
		CFG_MAX_RETENTION = 2'd1,
		CFG_SHAPE_OFFSET  = 2'd2,
		CFG_SHAPE_SLOPE   = 2'd3
	} cfg_index_t;

	// one step of the 2^frac product
	typedef struct packed {
		logic signed [11:0] k;
		logic [15:0]        frac;
		logic [16:0]        phi;
		logic [23:0]        rain;
		logic [31:0]        m;
	} exp_stage_t;

	localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

	localparam int POW2_FRAC_DEPTH = 12;
	// 2^(2^-i) in Q1.30, i = 1..12
	localparam logic [30:0] POW2_FRAC [POW2_FRAC_DEPTH] = '{
		31'd1518500250, 31'd1276901417, 31'd1170923762, 31'd1121280436,
		31'd1097253708, 31'd1085434106, 31'd1079572136, 31'd1076653033,
		31'd1075196443, 31'd1074468887, 31'd1074105294, 31'd1073923544
	};

	localparam logic [30:0] CN_NUMER  = 31'd1664614400; // 65536 * 25400
	localparam logic [24:0] CN_OFFSET = 25'd65024;      // 254 * 256
	localparam logic [25:0] IA_RECIP  = 26'd53687092;   // ceil(2^28 / 5)
	localparam logic [23:0] RUNOFF_MAX = 24'hFF_FFFF;

endpackage

// File: rtl/curve_number_runoff_unit.sv
// ---------------------------------------------------------------------------
// curve_number_runoff_unit
// Curve number runoff kernel: moisture excess, retention, initial
// abstraction, curve number and runoff depth for one step.
// ---------------------------------------------------------------------------
// Usage:
//  - item channel (item_valid / item_stall / item) takes one step's two
//    store moistures and rainfall; result channel gives one result per item.
//  - cfg channel writes wilting_sum, max_retention, shape_offset and
//    shape_slope by index; cfg_ready is always high. Write only while idle.
//  - Fully pipelined: one transaction per cycle in and out when the
//    receiver does not stall.
//  - Pipeline depth includes the two 24-stage bit-per-stage dividers in
//    series and one stage per 2^frac table bit.
//  - A result_stall with a result waiting freezes the whole pipeline and
//    raises item_stall in the same cycle; nothing is lost or repeated.
//  - Reset clears all valid bits and loads the registers' reset values.
// ---------------------------------------------------------------------------
`include "curve_number_runoff_unit_assert.svh"

module curve_number_runoff_unit #(
	parameter int EXP_TABLE_BITS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  cnr_pkg::item_t      item,
	output logic                result_valid,
	input  logic                result_stall,
	output cnr_pkg::result_t    result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  cnr_pkg::cfg_index_t cfg_index,
	input  logic [23:0]         cfg_data
);

	import cnr_pkg::*;

	// configuration
	logic [16:0]        wilting_sum_q;
	logic [23:0]        max_retention_q;
	logic signed [23:0] shape_offset_q;
	logic signed [23:0] shape_slope_q;

	// global advance: pipeline moves unless a finished result is held
	logic en;

	// front end
	logic               vld_s1, vld_s2, vld_s3, vld_s4;
	logic [16:0]        phi_s1, phi_s2, phi_s3, phi_s4;
	logic [23:0]        rain_s1, rain_s2, rain_s3, rain_s4;
	logic signed [41:0] wphi_s2;
	logic signed [26:0] t_s3;
	logic signed [27:0] v_s4;

	// 2^frac product, one table bit per stage
	exp_stage_t exp_s5     [EXP_TABLE_BITS];
	logic       exp_vld_s5 [EXP_TABLE_BITS];

	logic               vld_s6, vld_s7;
	logic [48:0]        p_s6;
	logic signed [12:0] sh_s6;
	logic [16:0]        phi_s6, phi_s7;
	logic [23:0]        rain_s6, rain_s7;
	logic [62:0]        den_s7;

	// retention divider
	logic        sdiv_vld;
	logic [23:0] sdiv_quo;
	logic [40:0] sdiv_side;

	logic        vld_s8, vld_s9, vld_s10, vld_s11;
	logic [50:0] iaprod_s8;
	logic [23:0] s_s8, s_s9, s_s10, s_s11;
	logic [16:0] phi_s8, phi_s9, phi_s10, phi_s11;
	logic [23:0] rain_s8;
	logic [23:0] ia_s9, ia_s10, ia_s11;
	logic        ge_s9, ge_s10;
	logic [23:0] d_s9;
	logic [27:0] den5_s9, den5_s10, den5_s11;
	logic [30:0] cnum_s9, cnum_s10, cnum_s11;
	logic [24:0] cden_s9, cden_s10, cden_s11;
	logic [47:0] dd_s10;
	logic [50:0] num5_s11;
	logic        ovf_s11, zero_s11;

	// curve number and runoff dividers
	logic        cdiv_vld, rdiv_vld;
	logic [23:0] cdiv_quo, rdiv_quo;
	logic [64:0] cdiv_side;
	logic [1:0]  rdiv_side;

	logic    result_vld_q;
	result_t result_q;

	assign en         = !(result_vld_q && result_stall);
	assign item_stall = !en;
	assign cfg_ready  = 1'b1;

	// -----------------------------------------------------------------------
	// configuration registers
	// -----------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wilting_sum_q   <= '0;
			max_retention_q <= 24'd64000;
			shape_offset_q  <= '0;
			shape_slope_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_WILTING_SUM:   wilting_sum_q   <= cfg_data[16:0];
				CFG_MAX_RETENTION: max_retention_q <= cfg_data;
				CFG_SHAPE_OFFSET:  shape_offset_q  <= cfg_data;
				CFG_SHAPE_SLOPE:   shape_slope_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// -----------------------------------------------------------------------
	// s1..s4: phi, t = w1 - w2*phi, v = -t * log2(e)
	// -----------------------------------------------------------------------
	logic [16:0]        msum;
	logic signed [27:0] neg_t;
	logic signed [59:0] vprod;

	assign msum  = 17'(item.moisture_a) + 17'(item.moisture_b);
	assign neg_t = -28'(t_s3);
	assign vprod = 60'(neg_t) * 60'($signed({1'b0, LOG2E_Q30}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= item_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// clamp at zero below wilting
			phi_s1  <= (msum > wilting_sum_q) ? msum - wilting_sum_q : '0;
			rain_s1 <= item.rainfall;
			wphi_s2 <= 42'(shape_slope_q) * 42'($signed({1'b0, phi_s1}));
			phi_s2  <= phi_s1;
			rain_s2 <= rain_s1;
			// arithmetic shift gives the floor
			t_s3    <= 27'(shape_offset_q) - 27'(wphi_s2 >>> 16);
			phi_s3  <= phi_s2;
			rain_s3 <= rain_s2;
			v_s4    <= 28'(vprod >>> 30);
			phi_s4  <= phi_s3;
			rain_s4 <= rain_s3;
		end
	end

	// -----------------------------------------------------------------------
	// s5: m = prod of 2^(2^-i) over set fraction bits, rounded each step
	// -----------------------------------------------------------------------
	localparam logic [62:0] M_ROUND = 63'h2000_0000;

	for (genvar g = 0; g < EXP_TABLE_BITS; g++) begin : g_exp
		exp_stage_t st_in;
		exp_stage_t st_out;
		logic       vld_in;
		logic [62:0] mprod;
		logic [62:0] mrnd;

		if (g == 0) begin : g_first
			assign st_in.k    = v_s4[27:16];
			assign st_in.frac = v_s4[15:0];
			assign st_in.phi  = phi_s4;
			assign st_in.rain = rain_s4;
			assign st_in.m    = 32'h4000_0000;
			assign vld_in     = vld_s4;
		end else begin : g_next
			assign st_in  = exp_s5[g-1];
			assign vld_in = exp_vld_s5[g-1];
		end

		assign mprod = 63'(st_in.m) * 63'(POW2_FRAC[g]);
		assign mrnd  = (mprod + M_ROUND) >> 30;

		always_comb begin
			st_out   = st_in;
			st_out.m = st_in.frac[15-g] ? 32'(mrnd) : st_in.m;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				exp_vld_s5[g] <= 1'b0;
			end else if (en) begin
				exp_vld_s5[g] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				exp_s5[g] <= st_out;
			end
		end
	end

	// -----------------------------------------------------------------------
	// s6: P = phi * m; s7: X = P * 2^(k-14), clamped at 2^62
	// -----------------------------------------------------------------------
	localparam logic [111:0] X_LIMIT_W = 112'h4000_0000_0000_0000;
	localparam logic [62:0]  X_LIMIT   = 63'h4000_0000_0000_0000;
	localparam logic [62:0]  X_ONE     = 63'h1_0000_0000;

	exp_stage_t  exp_last;
	logic [111:0] xwide;
	logic [12:0]  nsh;
	logic [62:0]  xval;

	assign exp_last = exp_s5[EXP_TABLE_BITS-1];
	assign xwide    = 112'(p_s6) << sh_s6[5:0];
	assign nsh      = 13'(-sh_s6);

	always_comb begin
		xval = '0;
		if (p_s6 == '0) begin
			xval = '0;
		end else if (!sh_s6[12]) begin
			if (sh_s6 >= 13'sd62 || xwide > X_LIMIT_W) begin
				xval = X_LIMIT;
			end else begin
				xval = 63'(xwide);
			end
		end else if (nsh >= 13'd63) begin
			xval = '0;
		end else begin
			xval = 63'(p_s6 >> nsh[5:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s6 <= exp_vld_s5[EXP_TABLE_BITS-1];
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s6    <= 49'(exp_last.phi) * 49'(exp_last.m);
			sh_s6   <= 13'(exp_last.k) - 13'sd14;
			phi_s6  <= exp_last.phi;
			rain_s6 <= exp_last.rain;
			den_s7  <= X_ONE + xval;
			phi_s7  <= phi_s6;
			rain_s7 <= rain_s6;
		end
	end

	// S = Smax * 2^32 / (2^32 + X)
	cnr_div_pipe #(
		.NUM_W  (56),
		.DEN_W  (63),
		.Q_W    (24),
		.SIDE_W (41)
	) u_sdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s7),
		.numer    ({max_retention_q, 32'd0}),
		.denom    (den_s7),
		.side_in  ({phi_s7, rain_s7}),
		.out_vld  (sdiv_vld),
		.quot     (sdiv_quo),
		.side_out (sdiv_side)
	);

	// -----------------------------------------------------------------------
	// s8..s11: Ia = round(S/5) by reciprocal, runoff operands, overflow
	// -----------------------------------------------------------------------
	logic [23:0] ia_c;
	logic [24:0] cden_c;

	assign ia_c   = 24'(iaprod_s8 >> 28);
	assign cden_c = 25'(s_s8) + CN_OFFSET;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
		end else if (en) begin
			vld_s8  <= sdiv_vld;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			iaprod_s8 <= (51'(sdiv_quo) + 51'd2) * 51'(IA_RECIP);
			s_s8      <= sdiv_quo;
			phi_s8    <= sdiv_side[40:24];
			rain_s8   <= sdiv_side[23:0];

			ia_s9     <= ia_c;
			ge_s9     <= rain_s8 >= ia_c;
			d_s9      <= rain_s8 - ia_c;
			den5_s9   <= 28'(rain_s8) * 28'd5 + 28'(s_s8) * 28'd4;
			cden_s9   <= cden_c;
			cnum_s9   <= CN_NUMER + 31'(cden_c >> 1);
			s_s9      <= s_s8;
			phi_s9    <= phi_s8;

			dd_s10    <= 48'(d_s9) * 48'(d_s9);
			ge_s10    <= ge_s9;
			den5_s10  <= den5_s9;
			cden_s10  <= cden_s9;
			cnum_s10  <= cnum_s9;
			ia_s10    <= ia_s9;
			s_s10     <= s_s9;
			phi_s10   <= phi_s9;

			num5_s11  <= 51'(dd_s10) * 51'd5;
			// quotient saturates when 5d^2 >= den * 2^24
			ovf_s11   <= (52'(dd_s10) * 52'd5) >= {den5_s10, 24'd0};
			zero_s11  <= !ge_s10 || (den5_s10 == '0);
			den5_s11  <= den5_s10;
			cden_s11  <= cden_s10;
			cnum_s11  <= cnum_s10;
			ia_s11    <= ia_s10;
			s_s11     <= s_s10;
			phi_s11   <= phi_s10;
		end
	end

	// curve number, rounded to nearest through the numerator offset
	cnr_div_pipe #(
		.NUM_W  (31),
		.DEN_W  (25),
		.Q_W    (24),
		.SIDE_W (65)
	) u_cdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s11),
		.numer    (cnum_s11),
		.denom    (cden_s11),
		.side_in  ({phi_s11, s_s11, ia_s11}),
		.out_vld  (cdiv_vld),
		.quot     (cdiv_quo),
		.side_out (cdiv_side)
	);

	// runoff = 5(R-Ia)^2 / (5R + 4S); result ignored on overflow or zero
	cnr_div_pipe #(
		.NUM_W  (51),
		.DEN_W  (28),
		.Q_W    (24),
		.SIDE_W (2)
	) u_rdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s11),
		.numer    (num5_s11),
		.denom    (den5_s11),
		.side_in  ({ovf_s11, zero_s11}),
		.out_vld  (rdiv_vld),
		.quot     (rdiv_quo),
		.side_out (rdiv_side)
	);

	// -----------------------------------------------------------------------
	// output register
	// -----------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_vld_q <= 1'b0;
		end else if (en) begin
			result_vld_q <= cdiv_vld && rdiv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_q.moisture_excess     <= cdiv_side[64:48];
			result_q.retention           <= cdiv_side[47:24];
			result_q.initial_abstraction <= cdiv_side[23:0];
			result_q.curve_number        <= 15'(cdiv_quo);
			if (rdiv_side[0]) begin
				result_q.runoff <= '0;
			end else if (rdiv_side[1]) begin
				result_q.runoff <= RUNOFF_MAX;
			end else begin
				result_q.runoff <= rdiv_quo;
			end
		end
	end

	assign result_valid = result_vld_q;
	assign result       = result_q;

	// -----------------------------------------------------------------------
	// assertions
	// -----------------------------------------------------------------------
	`CNR_ASSERT(a_div_aligned, cdiv_vld == rdiv_vld, "divider valids out of step")
	`CNR_ASSERT(a_cn_range, result_valid |-> result.curve_number <= 15'd25600,
		"curve number above 100")
	`CNR_ASSERT(a_ia_le_s,
		result_valid |-> result.initial_abstraction <= result.retention,
		"initial abstraction above retention")
	`CNR_ASSERT(a_cn_at_zero_s,
		result_valid && result.retention == '0 |-> result.curve_number == 15'd25600,
		"zero retention must give curve number 100")
	`CNR_ASSERT_ALWAYS(a_stall_freeze,
		$past(result_vld_q && result_stall) && arst_n && $past(arst_n)
			|-> $stable(vld_s11),
		"pipeline moved while result held")

endmodule

// File: rtl/cnr_div_pipe.sv
// ---------------------------------------------------------------------------
// cnr_div_pipe
// Restoring divider, one quotient bit per register stage, with sideband.
// Quotient must fit in Q_W bits.
// ---------------------------------------------------------------------------
module cnr_div_pipe #(
	parameter int NUM_W  = 56,
	parameter int DEN_W  = 63,
	parameter int Q_W    = 24,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [NUM_W-1:0]  numer,
	input  logic [DEN_W-1:0]  denom,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_vld,
	output logic [Q_W-1:0]    quot,
	output logic [SIDE_W-1:0] side_out
);

	localparam int W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

	logic              vld_q  [Q_W];
	logic [NUM_W-1:0]  rem_q  [Q_W];
	logic [DEN_W-1:0]  den_q  [Q_W];
	logic [Q_W-1:0]    quo_q  [Q_W];
	logic [SIDE_W-1:0] side_q [Q_W];

	for (genvar g = 0; g < Q_W; g++) begin : g_step
		localparam int B = Q_W - 1 - g;
		logic              vld_in;
		logic [NUM_W-1:0]  rem_in;
		logic [DEN_W-1:0]  den_in;
		logic [Q_W-1:0]    quo_in;
		logic [Q_W-1:0]    quo_nx;
		logic [SIDE_W-1:0] sd_in;
		logic [W-1:0]      trial;
		logic              fits;

		if (g == 0) begin : g_first
			assign vld_in = in_vld;
			assign rem_in = numer;
			assign den_in = denom;
			assign quo_in = '0;
			assign sd_in  = side_in;
		end else begin : g_next
			assign vld_in = vld_q[g-1];
			assign rem_in = rem_q[g-1];
			assign den_in = den_q[g-1];
			assign quo_in = quo_q[g-1];
			assign sd_in  = side_q[g-1];
		end

		assign trial  = W'(den_in) << B;
		assign fits   = W'(rem_in) >= trial;
		assign quo_nx = quo_in | (Q_W'(fits) << B);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[g] <= 1'b0;
			end else if (en) begin
				vld_q[g] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[g]  <= fits ? rem_in - NUM_W'(trial) : rem_in;
				den_q[g]  <= den_in;
				quo_q[g]  <= quo_nx;
				side_q[g] <= sd_in;
			end
		end
	end

	assign out_vld  = vld_q[Q_W-1];
	assign quot     = quo_q[Q_W-1];
	assign side_out = side_q[Q_W-1];

endmodule
